[rtl/core/mpcm_pkg.sv]
// ============================================================================
// mpcm_pkg
// Shared types, constants and tables of the multichannel PCM sample player:
// item structs, mode and register codes, register file layout, pitch table.
// ============================================================================
package mpcm_pkg;

    // Default sizes of the instance.
    localparam int CHANNELS_DEF      = 16;
    localparam int ROM_ADDR_BITS_DEF = 20;

    // Fixed field widths.
    localparam int BYTE_W      = 8;
    localparam int CMD_ADDR_W  = 20;
    localparam int SAMPLE_W    = 16;
    localparam int CH_ADDR_W   = 24;

    // Configuration port.
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 20;
    localparam int BANK_SHIFT_W  = 5;
    localparam int BANK_MASK_W   = 8;
    localparam int REGION_MASK_W = 20;

    localparam logic [BANK_SHIFT_W-1:0]  BANK_SHIFT_RST  = '0;
    localparam logic [BANK_MASK_W-1:0]   BANK_MASK_RST   = 8'd112;
    localparam logic [REGION_MASK_W-1:0] REGION_MASK_RST = 20'hFFFFF;

    // Register file: 256 bytes kept as 32 rows of 8 bytes. Row ch holds the
    // first bank of channel ch, row 16+ch the second bank.
    localparam int RF_ROWS      = 32;
    localparam int RF_ROW_W     = 5;
    localparam int RF_ROW_BYTES = 8;
    localparam int RF_ROW_BITS  = RF_ROWS * 0 + RF_ROW_BYTES * BYTE_W;
    localparam int BYTE_SEL_W   = 3;
    localparam int CH_ROW_W     = 4;
    localparam logic [BYTE_W-1:0] RF_RESET_BYTE = 8'hFF;

    // Byte positions inside the first bank row.
    localparam int B_LVOL     = 2;
    localparam int B_RVOL     = 3;
    localparam int B_LOOP_MID = 4;
    localparam int B_LOOP_HI  = 5;
    localparam int B_END_HI   = 6;
    localparam int B_DELTA    = 7;
    // Byte positions inside the second bank row.
    localparam int B_ADDR_MID = 4;
    localparam int B_ADDR_HI  = 5;
    localparam int B_FLAGS    = 6;

    // Flag bits.
    localparam int FLAG_INACTIVE = 0;
    localparam int FLAG_NO_LOOP  = 1;

    localparam logic [BYTE_W-1:0] SAMPLE_OFFSET = 8'h80;

    typedef enum logic [1:0] {
        MODE_REG_WR = 2'd0,
        MODE_REG_RD = 2'd1,
        MODE_ROM_WR = 2'd2,
        MODE_TICK   = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BANK_SHIFT  = 2'd0,
        CFG_BANK_MASK   = 2'd1,
        CFG_REGION_MASK = 2'd2
    } cfg_index_t;

    typedef enum logic {
        KIND_READ   = 1'b0,
        KIND_SAMPLE = 1'b1
    } kind_t;

    typedef struct packed {
        mode_t                  mode;
        logic [CMD_ADDR_W-1:0]  address;
        logic [BYTE_W-1:0]      data;
    } cmd_t;

    typedef struct packed {
        kind_t                      kind;
        logic [BYTE_W-1:0]          read_data;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } result_t;

    // Address step per output sample: floor(delta * 320 / 441), the ratio of
    // the 32 kHz source rate to the 44.1 kHz output rate.
    typedef logic [255:0][BYTE_W-1:0] step_table_t;

    function automatic step_table_t build_step_table();
        step_table_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = BYTE_W'((i * 320) / 441);
        end
        return t;
    endfunction

    localparam step_table_t STEP_TABLE = build_step_table();

endpackage

[rtl/core/multichannel_pcm_sample_player.sv]
// ============================================================================
// multichannel_pcm_sample_player
// Sixteen-channel 8-bit PCM sample player with a stereo mixer. The channel
// registers live in a row-organized register file memory and the samples in
// a byte-wide ROM memory; a tick walks the channels through a short pipeline.
// ============================================================================
//
//  Channel  | Signals                                  | Handshake
//  ---------+------------------------------------------+---------------------------
//  command  | start, busy, cmd (mode, address, data)   | taken when start & !busy
//  result   | done, result (kind, read_data, samples)  | one-cycle strobe, no stall
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data| taken when valid & ready
//
// Register writes and ROM writes complete at the edge that takes the item and
// never raise busy. A register read holds busy while in ST_READ, and its
// result strobes from the done register once that state ends. A sample tick
// holds busy while the register file read ports start one channel per cycle
// into a four-stage pipeline (register read, address update and ROM read,
// multiply, accumulate), and the tick ends when the pipeline has drained.
// Reset is asynchronous and active low; the register file reads as 0xFF per
// byte until written, tracked by one valid flop per byte, so no clearing pass
// is needed. The result register is separate from the control, so the next
// item is taken while a result is on the ports; the receiver cannot stall.
//
module multichannel_pcm_sample_player #(
    parameter int CHANNELS      = mpcm_pkg::CHANNELS_DEF,
    parameter int ROM_ADDR_BITS = mpcm_pkg::ROM_ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  mpcm_pkg::cmd_t                    cmd,
    output logic                              done,
    output mpcm_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mpcm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mpcm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mpcm_pkg::*;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W     = $clog2(CHANNELS + 1);
    localparam int ROM_DEPTH = 1 << ROM_ADDR_BITS;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_TICK = 3'b100
    } state_t;

    // Bytes that were never written read as the reset value.
    function automatic logic [RF_ROW_BITS-1:0] merge_row(
        input logic [RF_ROW_BITS-1:0]  row,
        input logic [RF_ROW_BYTES-1:0] vld
    );
        logic [RF_ROW_BITS-1:0] m;
        for (int b = 0; b < RF_ROW_BYTES; b++)
        begin
            m[b*BYTE_W +: BYTE_W] = vld[b] ? row[b*BYTE_W +: BYTE_W] : RF_RESET_BYTE;
        end
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Control and configuration registers
    // ------------------------------------------------------------------
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          issue_cnt_reg;
    logic [BANK_SHIFT_W-1:0]   bank_shift_reg;
    logic [BANK_MASK_W-1:0]    bank_mask_reg;
    logic [REGION_MASK_W-1:0]  region_mask_reg;
    logic [BYTE_SEL_W-1:0]     rd_sel_reg;
    logic                      done_reg;
    result_t                   result_reg, result_next;
    logic [SAMPLE_W-1:0]       acc_l_reg, acc_r_reg;

    logic accept;
    logic issue_done;
    logic issuing;
    logic tick_finish;
    logic [CH_W-1:0]      ch_issue;
    logic [CH_ROW_W-1:0]  ch_row;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign result    = result_reg;

    assign issue_done = (issue_cnt_reg == CNT_W'(CHANNELS));
    assign issuing    = (state_reg == ST_TICK) && !issue_done;
    assign ch_issue   = issue_cnt_reg[CH_W-1:0];
    assign ch_row     = CH_ROW_W'(ch_issue);

    // ------------------------------------------------------------------
    // Register file memory: 32 rows of 8 bytes, byte write enables, two
    // registered read ports (one per bank during a tick).
    // ------------------------------------------------------------------
    logic [RF_ROW_BITS-1:0]   rf_mem [RF_ROWS];
    logic [RF_ROW_BYTES-1:0]  rf_vld_reg [RF_ROWS];

    logic                     wr_en;
    logic [RF_ROW_W-1:0]      wr_row;
    logic [RF_ROW_BYTES-1:0]  wr_be;
    logic [RF_ROW_BITS-1:0]   wr_data;
    logic [RF_ROW_W-1:0]      rd_row_a, rd_row_b;
    logic [RF_ROW_BITS-1:0]   rowa_q, rowb_q;
    logic [RF_ROW_BYTES-1:0]  va_q, vb_q;

    // ------------------------------------------------------------------
    // Sample ROM memory: one port shared by ROM writes and tick reads.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0]         rom_mem [ROM_DEPTH];
    logic                      rom_we;
    logic [ROM_ADDR_BITS-1:0]  rom_addr;
    logic [ROM_ADDR_BITS-1:0]  rom_idx;
    logic [ROM_ADDR_BITS-1:0]  bank_base;
    logic [ROM_ADDR_BITS-1:0]  bank_off;
    logic [BYTE_W-1:0]         rom_q;

    // Low address byte of each channel, kept in flops.
    logic [BYTE_W-1:0] low_reg [CHANNELS];

    // ------------------------------------------------------------------
    // Tick pipeline
    // ------------------------------------------------------------------
    // Stage 1: register rows arrive.
    logic                  s1_v_reg;
    logic [CH_W-1:0]       s1_ch_reg;
    // Stage 2: address update, write back, ROM read.
    logic                  s2_v_reg;
    logic                  s2_act_reg;
    logic [CH_W-1:0]       s2_ch_reg;
    logic [CH_ADDR_W-1:0]  s2_addr_reg;
    logic [BYTE_W-1:0]     s2_flags_reg;
    logic [BYTE_W-1:0]     s2_delta_reg;
    logic [BYTE_W-1:0]     s2_lvol_reg, s2_rvol_reg;
    // Stage 3: ROM byte arrives, multiply.
    logic                  s3_v_reg;
    logic [BYTE_W-1:0]     s3_lvol_reg, s3_rvol_reg;
    // Stage 4: products ready, accumulate.
    logic                  s4_v_reg;
    logic [SAMPLE_W-1:0]   p_l_reg, p_r_reg;

    // Stage 1 decode of the channel rows.
    logic [RF_ROW_BITS-1:0] row_a, row_b;
    logic [BYTE_W-1:0]      s1_flags;
    logic [CH_ADDR_W-1:0]   s1_cur;
    logic [BYTE_W-1:0]      s1_end_next;
    logic                   s1_at_end;
    logic                   s1_skip;
    logic                   s1_stop;
    logic [CH_ADDR_W-1:0]   s1_addr;

    assign row_a       = merge_row(rowa_q, va_q);
    assign row_b       = merge_row(rowb_q, vb_q);
    assign s1_flags    = row_b[B_FLAGS*BYTE_W +: BYTE_W];
    assign s1_cur      = {row_b[B_ADDR_HI*BYTE_W +: BYTE_W],
                          row_b[B_ADDR_MID*BYTE_W +: BYTE_W],
                          low_reg[s1_ch_reg]};
    assign s1_end_next = row_a[B_END_HI*BYTE_W +: BYTE_W] + BYTE_W'(1);
    assign s1_at_end   = (s1_cur[CH_ADDR_W-1 -: BYTE_W] == s1_end_next);
    assign s1_skip     = s1_flags[FLAG_INACTIVE];
    // The end was reached with looping off: the channel goes inactive.
    assign s1_stop     = !s1_skip && s1_at_end && s1_flags[FLAG_NO_LOOP];
    assign s1_addr     = s1_at_end ? {row_a[B_LOOP_HI*BYTE_W +: BYTE_W],
                                      row_a[B_LOOP_MID*BYTE_W +: BYTE_W],
                                      BYTE_W'(0)}
                                   : s1_cur;

    // Stage 2: next address and banked ROM index.
    logic [CH_ADDR_W-1:0] s2_new_addr;
    logic                 s2_stop_reg;

    assign s2_new_addr = s2_addr_reg + CH_ADDR_W'(STEP_TABLE[s2_delta_reg]);
    assign bank_base   = ROM_ADDR_BITS'(s2_flags_reg & bank_mask_reg) << bank_shift_reg;
    assign bank_off    = ROM_ADDR_BITS'(s2_addr_reg[CH_ADDR_W-1:BYTE_W]
                                        & region_mask_reg[CH_ADDR_W-BYTE_W-1:0]);
    assign rom_idx     = bank_base + bank_off;

    // Stage 3: remove the offset by flipping the top bit, then scale.
    logic signed [BYTE_W-1:0]   s3_sample;
    logic signed [BYTE_W+BYTE_W:0] prod_l, prod_r;

    assign s3_sample = $signed(rom_q ^ SAMPLE_OFFSET);
    assign prod_l    = s3_sample * $signed({1'b0, s3_lvol_reg});
    assign prod_r    = s3_sample * $signed({1'b0, s3_rvol_reg});

    assign tick_finish = (state_reg == ST_TICK) && issue_done &&
                         !(s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg);

    // ------------------------------------------------------------------
    // Memory port selection
    // ------------------------------------------------------------------
    always_comb
    begin
        if (state_reg == ST_TICK)
        begin
            rd_row_a = {1'b0, ch_row};
        end
        else
        begin
            rd_row_a = cmd.address[BYTE_SEL_W +: RF_ROW_W];
        end
        rd_row_b = {1'b1, ch_row};
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_row  = cmd.address[BYTE_SEL_W +: RF_ROW_W];
        wr_be   = '0;
        wr_data = {RF_ROW_BYTES{cmd.data}};
        priority if (accept && cmd.mode == MODE_REG_WR)
        begin
            wr_en = 1'b1;
            wr_be = RF_ROW_BYTES'(1) << cmd.address[BYTE_SEL_W-1:0];
        end
        else if (s2_v_reg && s2_stop_reg)
        begin
            wr_en  = 1'b1;
            wr_row = {1'b1, CH_ROW_W'(s2_ch_reg)};
            wr_be  = RF_ROW_BYTES'(1) << B_FLAGS;
            wr_data[B_FLAGS*BYTE_W +: BYTE_W] = s2_flags_reg | BYTE_W'(1 << FLAG_INACTIVE);
        end
        else if (s2_v_reg && s2_act_reg)
        begin
            wr_en  = 1'b1;
            wr_row = {1'b1, CH_ROW_W'(s2_ch_reg)};
            wr_be  = (RF_ROW_BYTES'(1) << B_ADDR_MID) | (RF_ROW_BYTES'(1) << B_ADDR_HI);
            wr_data[B_ADDR_MID*BYTE_W +: BYTE_W] = s2_new_addr[2*BYTE_W-1:BYTE_W];
            wr_data[B_ADDR_HI*BYTE_W +: BYTE_W]  = s2_new_addr[CH_ADDR_W-1:2*BYTE_W];
        end
    end

    assign rom_we   = accept && (cmd.mode == MODE_ROM_WR);
    assign rom_addr = rom_we ? ROM_ADDR_BITS'(cmd.address) : rom_idx;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int b = 0; b < RF_ROW_BYTES; b++)
            begin
                if (wr_be[b])
                begin
                    rf_mem[wr_row][b*BYTE_W +: BYTE_W] <= wr_data[b*BYTE_W +: BYTE_W];
                end
            end
        end
        rowa_q <= rf_mem[rd_row_a];
        rowb_q <= rf_mem[rd_row_b];
        va_q   <= rf_vld_reg[rd_row_a];
        vb_q   <= rf_vld_reg[rd_row_b];
    end

    always_ff @(posedge clk)
    begin
        if (rom_we)
        begin
            rom_mem[rom_addr] <= cmd.data;
        end
        rom_q <= rom_mem[rom_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < RF_ROWS; r++)
            begin
                rf_vld_reg[r] <= '0;
            end
        end
        else if (wr_en)
        begin
            rf_vld_reg[wr_row] <= rf_vld_reg[wr_row] | wr_be;
        end
    end

    // Low address bytes: cleared when a channel stops, advanced otherwise.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                low_reg[c] <= '0;
            end
        end
        else if (s2_v_reg && s2_stop_reg)
        begin
            low_reg[s2_ch_reg] <= '0;
        end
        else if (s2_v_reg && s2_act_reg)
        begin
            low_reg[s2_ch_reg] <= s2_new_addr[BYTE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_shift_reg  <= BANK_SHIFT_RST;
            bank_mask_reg   <= BANK_MASK_RST;
            region_mask_reg <= REGION_MASK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BANK_SHIFT:  bank_shift_reg  <= cfg_data[BANK_SHIFT_W-1:0];
                CFG_BANK_MASK:   bank_mask_reg   <= cfg_data[BANK_MASK_W-1:0];
                CFG_REGION_MASK: region_mask_reg <= cfg_data[REGION_MASK_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        result_next = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.mode == MODE_REG_RD)
                begin
                    state_next = ST_READ;
                end
                else if (accept && cmd.mode == MODE_TICK)
                begin
                    state_next = ST_TICK;
                end
            end
            ST_READ:
            begin
                state_next               = ST_IDLE;
                result_next.kind         = KIND_READ;
                result_next.read_data    = row_a[rd_sel_reg*BYTE_W +: BYTE_W];
                result_next.left_sample  = '0;
                result_next.right_sample = '0;
            end
            ST_TICK:
            begin
                if (tick_finish)
                begin
                    state_next               = ST_IDLE;
                    result_next.kind         = KIND_SAMPLE;
                    result_next.read_data    = '0;
                    result_next.left_sample  = $signed(acc_l_reg);
                    result_next.right_sample = $signed(acc_r_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            issue_cnt_reg <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_READ) || tick_finish;
            if (accept && cmd.mode == MODE_TICK)
            begin
                issue_cnt_reg <= '0;
            end
            else if (issuing)
            begin
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            end
            s1_v_reg <= issuing;
            // Inactive channels leave the pipeline here.
            s2_v_reg <= s1_v_reg && !s1_skip;
            s3_v_reg <= s2_v_reg && s2_act_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    // Payload registers of the item and the pipeline.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            rd_sel_reg <= cmd.address[BYTE_SEL_W-1:0];
        end

        s1_ch_reg    <= ch_issue;
        s2_ch_reg    <= s1_ch_reg;
        s2_act_reg   <= !s1_skip && !s1_stop;
        s2_stop_reg  <= s1_stop;
        s2_addr_reg  <= s1_addr;
        s2_flags_reg <= s1_flags;
        s2_delta_reg <= row_a[B_DELTA*BYTE_W +: BYTE_W];
        s2_lvol_reg  <= row_a[B_LVOL*BYTE_W +: BYTE_W];
        s2_rvol_reg  <= row_a[B_RVOL*BYTE_W +: BYTE_W];
        s3_lvol_reg  <= s2_lvol_reg;
        s3_rvol_reg  <= s2_rvol_reg;
        p_l_reg      <= prod_l[SAMPLE_W-1:0];
        p_r_reg      <= prod_r[SAMPLE_W-1:0];

        // The mix wraps modulo 2^16.
        if (accept && cmd.mode == MODE_TICK)
        begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (s4_v_reg)
        begin
            acc_l_reg <= acc_l_reg + p_l_reg;
            acc_r_reg <= acc_r_reg + p_r_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // During a tick the only register file writes are channel state updates
    // in the second bank.
    a_tick_writes_bank1: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg == ST_TICK) |-> wr_row[RF_ROW_W-1])
        else $error("tick wrote the first register bank");

    // The pipeline is empty whenever no tick is running.
    a_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_TICK) |-> !(s1_v_reg || s2_v_reg || s3_v_reg || s4_v_reg))
        else $error("channel pipeline busy outside a tick");

    // A stereo sample is only presented right after a tick has finished.
    a_sample_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.kind == KIND_SAMPLE) |-> $past(state_reg == ST_TICK))
        else $error("sample result without a tick");

endmodule

[tb/tb_multichannel_pcm_sample_player.sv]
// ============================================================================
// tb_multichannel_pcm_sample_player
// Self-checking testbench for the sixteen-channel PCM sample player. A
// behavioral copy of the register file, the per-channel low address bytes and
// the sample ROM predicts every register read and every mixed stereo sample;
// the results the block strobes out are compared field by field, in order.
// ============================================================================
module tb_multichannel_pcm_sample_player;

    import mpcm_pkg::*;

    localparam int NUM_CH           = CHANNELS_DEF;
    localparam int ROM_BITS         = ROM_ADDR_BITS_DEF;
    localparam int ROM_DEPTH        = 1 << ROM_BITS;
    localparam int SECOND_BANK_BASE = 128;
    localparam int SETTLE_CYCLES    = 8;
    localparam int TAIL_CYCLES      = 40;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    cmd_t                    cmd;
    logic                    done;
    result_t                 result;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    multichannel_pcm_sample_player DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Behavioral image of the block's state and configuration.
    logic [BYTE_W-1:0]        chan_regs [256];
    logic [BYTE_W-1:0]        addr_low [NUM_CH];
    logic [BYTE_W-1:0]        rom_image [ROM_DEPTH];
    bit                       rom_loaded [ROM_DEPTH];
    logic [BANK_SHIFT_W-1:0]  cur_bank_shift;
    logic [BANK_MASK_W-1:0]   cur_bank_mask;
    logic [REGION_MASK_W-1:0] cur_region_mask;

    // Results still owed by the block, oldest first.
    result_t expected_results [$];
    result_t oldest_result;
    int      fail_count;
    int      items_sent;
    int      idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The run is cut off here if the block stops answering.
    initial
    begin
        #2000000;
        $display("tb_multichannel_pcm_sample_player failed");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] chan_reg(input int ch, input bit second,
                                                   input int byte_pos);
        return BYTE_W'((second ? SECOND_BANK_BASE : 0) + 8 * ch + byte_pos);
    endfunction

    function automatic cmd_t make_cmd(input mode_t m, input logic [CMD_ADDR_W-1:0] a,
                                      input logic [BYTE_W-1:0] d);
        cmd_t c;
        c.mode    = m;
        c.address = a;
        c.data    = d;
        return c;
    endfunction

    // Works out whether a channel fetches a sample on the next tick, from
    // which ROM byte, and its playback position after any loop reload.
    function automatic bit channel_fetch(input int ch, output logic [ROM_BITS-1:0] idx,
                                         output logic [CH_ADDR_W-1:0] pos);
        int                b1;
        int                b2;
        logic [BYTE_W-1:0] flags;
        logic [BYTE_W-1:0] end_next;
        logic [63:0]       bank_base;
        b1       = 8 * ch;
        b2       = SECOND_BANK_BASE + 8 * ch;
        flags    = chan_regs[b2 + B_FLAGS];
        pos      = {chan_regs[b2 + B_ADDR_HI], chan_regs[b2 + B_ADDR_MID], addr_low[ch]};
        end_next = chan_regs[b1 + B_END_HI] + 8'd1;
        idx      = '0;
        if (flags[FLAG_INACTIVE])
            return 1'b0;
        if (pos[23:16] == end_next)
        begin
            if (flags[FLAG_NO_LOOP])
                return 1'b0;
            pos = {chan_regs[b1 + B_LOOP_HI], chan_regs[b1 + B_LOOP_MID], 8'h00};
        end
        bank_base = 64'(flags & cur_bank_mask) << cur_bank_shift;
        idx = ROM_BITS'(bank_base + 64'(pos[23:8] & cur_region_mask));
        return 1'b1;
    endfunction

    // One output sample: every active channel adds its scaled sample to the
    // 16-bit left and right sums and then steps its position.
    function automatic result_t mix_sample();
        result_t                 r;
        logic [SAMPLE_W-1:0]     lsum;
        logic [SAMPLE_W-1:0]     rsum;
        logic [ROM_BITS-1:0]     idx;
        logic [CH_ADDR_W-1:0]    pos;
        int                      b1;
        int                      b2;
        int                      smp;
        lsum = '0;
        rsum = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            b1 = 8 * ch;
            b2 = SECOND_BANK_BASE + 8 * ch;
            if (chan_regs[b2 + B_FLAGS][FLAG_INACTIVE])
                continue;
            if (!channel_fetch(ch, idx, pos))
            begin
                // End reached with looping off: the channel stops itself.
                chan_regs[b2 + B_FLAGS][FLAG_INACTIVE] = 1'b1;
                addr_low[ch] = '0;
                continue;
            end
            smp  = int'(rom_image[idx]) - int'(SAMPLE_OFFSET);
            lsum = lsum + SAMPLE_W'(smp * int'(chan_regs[b1 + B_LVOL]));
            rsum = rsum + SAMPLE_W'(smp * int'(chan_regs[b1 + B_RVOL]));
            pos  = pos + CH_ADDR_W'((int'(chan_regs[b1 + B_DELTA]) * 320) / 441);
            chan_regs[b2 + B_ADDR_MID] = pos[15:8];
            chan_regs[b2 + B_ADDR_HI]  = pos[23:16];
            addr_low[ch]               = pos[7:0];
        end
        r.kind         = KIND_SAMPLE;
        r.read_data    = '0;
        r.left_sample  = lsum;
        r.right_sample = rsum;
        return r;
    endfunction

    function automatic bit predict_command(input cmd_t c, output result_t r);
        r.kind         = KIND_READ;
        r.read_data    = '0;
        r.left_sample  = '0;
        r.right_sample = '0;
        case (c.mode)
            MODE_REG_WR:
            begin
                chan_regs[c.address[7:0]] = c.data;
                return 1'b0;
            end
            MODE_REG_RD:
            begin
                r.read_data = chan_regs[c.address[7:0]];
                return 1'b1;
            end
            MODE_ROM_WR:
            begin
                rom_image[c.address[ROM_BITS-1:0]]  = c.data;
                rom_loaded[c.address[ROM_BITS-1:0]] = 1'b1;
                return 1'b0;
            end
            default:
            begin
                r = mix_sample();
                return 1'b1;
            end
        endcase
    endfunction

    // Back to back unless idle_pct calls for a gap; mostly a short gap, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_level();
        case ($urandom_range(5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // Offers one item, waits until the block takes it and records what it
    // must answer. Start stays high when the next item follows at once.
    task automatic send_command(input cmd_t c);
        result_t r;
        int      gap;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (predict_command(c, r))
            expected_results.push_back(r);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Loads any ROM byte the coming tick will fetch that has never been
    // written, then sends the tick itself.
    task automatic send_tick();
        logic [ROM_BITS-1:0]  idx;
        logic [CH_ADDR_W-1:0] pos;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (channel_fetch(ch, idx, pos) && !rom_loaded[idx])
                send_command(make_cmd(MODE_ROM_WR, CMD_ADDR_W'(idx), rand_level()));
        end
        send_command(make_cmd(MODE_TICK, CMD_ADDR_W'($urandom), BYTE_W'($urandom)));
    endtask

    task automatic send_any_item();
        mode_t m;
        m = mode_t'($urandom_range(3));
        if (m == MODE_TICK)
            send_tick();
        else
            send_command(make_cmd(m, CMD_ADDR_W'($urandom), BYTE_W'($urandom)));
    endtask

    // Stops sending and waits until every owed result has come back.
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the three configuration registers (and the spare index when asked), valid held across them.
    task automatic configure(input logic [CFG_DATA_W-1:0] shift_v,
                             input logic [CFG_DATA_W-1:0] mask_v,
                             input logic [CFG_DATA_W-1:0] region_v,
                             input bit poke_spare);
        logic [CFG_INDEX_W-1:0] idx_list [4];
        logic [CFG_DATA_W-1:0]  val_list [4];
        idx_list = '{CFG_BANK_SHIFT, CFG_BANK_MASK, CFG_REGION_MASK, CFG_SPARE};
        val_list = '{shift_v, mask_v, region_v, CFG_DATA_W'($urandom)};
        for (int i = 0; i < (poke_spare ? 4 : 3); i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= val_list[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx_list[i])
                CFG_BANK_SHIFT:  cur_bank_shift  = val_list[i][BANK_SHIFT_W-1:0];
                CFG_BANK_MASK:   cur_bank_mask   = val_list[i][BANK_MASK_W-1:0];
                CFG_REGION_MASK: cur_region_mask = val_list[i][REGION_MASK_W-1:0];
                default:         ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Sets one channel up for playback, often close to or at its end
    // address, then plays a run of ticks with the odd register read between.
    task automatic program_channel(input int ch, input int ticks);
        logic [BYTE_W-1:0] end_hi;
        logic [BYTE_W-1:0] addr_hi;
        logic [BYTE_W-1:0] addr_mid;
        int                scenario;
        end_hi   = BYTE_W'($urandom);
        scenario = $urandom_range(2);
        addr_hi  = (scenario == 0) ? end_hi : (scenario == 1) ? end_hi + 8'd1
                                            : BYTE_W'($urandom);
        addr_mid = (scenario == 0) ? 8'hFF : BYTE_W'($urandom);
        send_command(make_cmd(MODE_REG_WR, {12'($urandom), chan_reg(ch, 0, B_LVOL)},
                              rand_level()));
        send_command(make_cmd(MODE_REG_WR, {12'($urandom), chan_reg(ch, 0, B_RVOL)},
                              rand_level()));
        send_command(make_cmd(MODE_REG_WR, {12'($urandom), chan_reg(ch, 0, B_LOOP_MID)},
                              BYTE_W'($urandom)));
        send_command(make_cmd(MODE_REG_WR, {12'($urandom), chan_reg(ch, 0, B_LOOP_HI)},
                              BYTE_W'($urandom)));
        send_command(make_cmd(MODE_REG_WR, {12'($urandom), chan_reg(ch, 0, B_END_HI)},
                              end_hi));
        send_command(make_cmd(MODE_REG_WR, {12'($urandom), chan_reg(ch, 0, B_DELTA)},
                              rand_level()));
        send_command(make_cmd(MODE_REG_WR, {12'($urandom), chan_reg(ch, 1, B_ADDR_MID)},
                              addr_mid));
        send_command(make_cmd(MODE_REG_WR, {12'($urandom), chan_reg(ch, 1, B_ADDR_HI)},
                              addr_hi));
        // Active, loop bit and bank bits random.
        send_command(make_cmd(MODE_REG_WR, {12'($urandom), chan_reg(ch, 1, B_FLAGS)},
                              {6'($urandom), 1'($urandom), 1'b0}));
        repeat (ticks)
        begin
            if ($urandom_range(3) == 0)
                send_command(make_cmd(MODE_REG_RD,
                                      {12'($urandom), chan_reg(ch, $urandom_range(1),
                                                               $urandom_range(7))},
                                      BYTE_W'($urandom)));
            send_tick();
        end
    endtask

    task automatic play_sequences(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(9);
            if (pick < 2)
                send_any_item();
            else if (pick == 2 && $urandom_range(7) == 0)
                wait_idle();
            else
                program_channel($urandom_range(NUM_CH - 1), $urandom_range(3, 10));
        end
    endtask

    // Reset values, register aliasing, both sample extremes, a loop reload
    // and a channel stopping at its end address.
    task automatic test_directed();
        idle_pct = 0;
        send_tick();
        send_command(make_cmd(MODE_REG_RD, {12'hF00, chan_reg(0, 1, B_FLAGS)}, 8'hA5));
        send_command(make_cmd(MODE_ROM_WR, 20'hFFFFF, 8'hFF));
        send_command(make_cmd(MODE_ROM_WR, 20'h0FFFF, 8'h00));
        send_command(make_cmd(MODE_ROM_WR, 20'h00000, 8'hFF));
        send_command(make_cmd(MODE_REG_WR, {12'hFFF, chan_reg(0, 1, B_FLAGS)}, 8'h00));
        send_command(make_cmd(MODE_REG_WR, {12'hABC, chan_reg(0, 0, B_RVOL)}, 8'h00));
        send_tick();
        send_command(make_cmd(MODE_REG_RD, {12'h000, chan_reg(0, 1, B_ADDR_MID)}, 8'h00));
        send_command(make_cmd(MODE_REG_RD, {12'h000, chan_reg(0, 1, B_ADDR_HI)}, 8'h00));
        // End byte one below the current high byte: next tick reloads the loop.
        send_command(make_cmd(MODE_REG_WR, {12'h000, chan_reg(0, 0, B_END_HI)}, 8'hFE));
        send_command(make_cmd(MODE_REG_WR, {12'h000, chan_reg(0, 0, B_LOOP_MID)}, 8'h00));
        send_command(make_cmd(MODE_REG_WR, {12'h000, chan_reg(0, 0, B_LOOP_HI)}, 8'h00));
        send_tick();
        // Back at the end with looping off: the channel goes inactive.
        send_command(make_cmd(MODE_REG_WR, {12'h000, chan_reg(0, 1, B_ADDR_HI)}, 8'hFF));
        send_command(make_cmd(MODE_REG_WR, {12'h000, chan_reg(0, 1, B_FLAGS)}, 8'h02));
        send_tick();
        send_command(make_cmd(MODE_REG_RD, {12'hFFF, chan_reg(0, 1, B_FLAGS)}, 8'hFF));
        send_command(make_cmd(MODE_REG_RD, {12'h000, chan_reg(0, 1, B_ADDR_HI)}, 8'h00));
        // Last channel with its reset registers at full volume.
        send_command(make_cmd(MODE_REG_WR, {12'h000, chan_reg(NUM_CH - 1, 1, B_FLAGS)},
                              8'h00));
        send_tick();
        send_tick();
        wait_idle();
    endtask

    // Channel playback under a range of bank and region settings.
    task automatic test_bank_settings();
        configure(20'd0, 20'h000FF, 20'hFFFFF, 1'b0);
        idle_pct = 0;
        play_sequences(150);
        wait_idle();
        configure(20'd31, 20'h000FF, 20'h00000, 1'b0);
        idle_pct = 30;
        play_sequences(150);
        wait_idle();
        configure(20'd4, 20'h00070, 20'h00FFF, 1'b0);
        idle_pct = 60;
        play_sequences(150);
        wait_idle();
        // A high bank base makes base plus offset run past the ROM.
        configure(20'd16, 20'h000F0, 20'hFFFFF, 1'b0);
        idle_pct = 15;
        play_sequences(150);
        wait_idle();
        configure(20'd0, 20'h00000, 20'h000FF, 1'b1);
        idle_pct = 40;
        play_sequences(150);
        wait_idle();
        configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  1'b1);
        idle_pct = 20;
        play_sequences(150);
        wait_idle();
    endtask

    // Unstructured items of every mode with random fields.
    task automatic test_random_items();
        int stop_at;
        configure(20'd12, 20'h00070, 20'hFFFFF, 1'b0);
        idle_pct = 35;
        stop_at  = items_sent + 150;
        while (items_sent < stop_at)
            send_any_item();
        wait_idle();
    endtask

    // The sender holds off until all results are back, several times over.
    task automatic test_pause_for_results();
        idle_pct = 10;
        repeat (5)
        begin
            program_channel($urandom_range(NUM_CH - 1), $urandom_range(2, 6));
            wait_idle();
        end
    endtask

    // Each strobed result is matched against the oldest prediction.
    task automatic check_field(input string name, input logic signed [16:0] want,
                               input logic signed [16:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no item waiting: kind %0d", result.kind);
                fail_count++;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                check_field("kind", oldest_result.kind, result.kind);
                check_field("read_data", oldest_result.read_data, result.read_data);
                check_field("left_sample", oldest_result.left_sample, result.left_sample);
                check_field("right_sample", oldest_result.right_sample,
                            result.right_sample);
            end
        end
    end

    initial
    begin
        fail_count = 0;
        items_sent = 0;
        idle_pct   = 0;
        foreach (chan_regs[i])
            chan_regs[i] = RF_RESET_BYTE;
        foreach (addr_low[i])
            addr_low[i] = '0;
        foreach (rom_loaded[i])
            rom_loaded[i] = 1'b0;
        cur_bank_shift  = BANK_SHIFT_RST;
        cur_bank_mask   = BANK_MASK_RST;
        cur_region_mask = REGION_MASK_RST;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cmd       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_bank_settings();
        test_random_items();
        test_pause_for_results();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_multichannel_pcm_sample_player passed");
        else
            $display("tb_multichannel_pcm_sample_player failed");
        $finish;
    end

endmodule
